>>> hw/rtl/gpej_pkg.sv
// Shared constants, types and exponential table for the Gaussian peak evaluator.
`timescale 1ns / 1ps
package gpej_pkg;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int EXP_BITS       = 20;
  localparam int ACC_W          = 25;
  localparam int E_W            = 17;

  typedef enum logic [2:0] {
    REG_OFFSET = 3'd0,
    REG_SLOPE  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_CENTRE = 3'd3,
    REG_WEIGHT = 3'd4
  } cfg_idx_t;

  // exp(-2^(k-16)) in Q0.24
  function automatic logic [23:0] exp_tab(input logic [4:0] k);
    logic [23:0] t;
    case (k)
      5'd0:  t = 24'd16776960;
      5'd1:  t = 24'd16776704;
      5'd2:  t = 24'd16776192;
      5'd3:  t = 24'd16775168;
      5'd4:  t = 24'd16773120;
      5'd5:  t = 24'd16769026;
      5'd6:  t = 24'd16760840;
      5'd7:  t = 24'd16744480;
      5'd8:  t = 24'd16711808;
      5'd9:  t = 24'd16646655;
      5'd10: t = 24'd16517109;
      5'd11: t = 24'd16261035;
      5'd12: t = 24'd15760736;
      5'd13: t = 24'd14805841;
      5'd14: t = 24'd13066109;
      5'd15: t = 24'd10175896;
      5'd16: t = 24'd6171993;
      5'd17: t = 24'd2270549;
      5'd18: t = 24'd307285;
      5'd19: t = 24'd5628;
      default: t = 24'd0;
    endcase
    return t;
  endfunction
endpackage

>>> hw/rtl/gaussian_peak_eval_jacobian_top.sv
// Top level: pipelined Gaussian peak plus linear background with Jacobian terms.
//
//  channel | ports                                   | handshake
//  in      | start, in_sample_x, in_last             | start & !busy (busy is 0)
//  out     | out_valid, out_model_value ... out_last | one-cycle strobe
//  cfg     | cfg_we, cfg_index, cfg_data             | write when cfg_we
//
// One beat per cycle; 29 register stages: four front stages (diff, square,
// split weight products, exponent argument), one per exponential bit, then
// e, height product, background sum, split derivative products and output.
// Reset clears the valid chain and loads register defaults.
// The receiver cannot stall, so the pipeline never stops and busy stays low.
`timescale 1ns / 1ps
module gaussian_peak_eval_jacobian_top #(
  parameter int WORD_WIDTH = gpej_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = gpej_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [WORD_WIDTH-1:0] in_sample_x,
  input  logic                         in_last,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [WORD_WIDTH-1:0]        cfg_data,
  output logic                         out_valid,
  output logic signed [WORD_WIDTH-1:0] out_model_value,
  output logic [gpej_pkg::E_W-1:0]     out_deriv_height,
  output logic signed [WORD_WIDTH-1:0] out_deriv_centre,
  output logic signed [WORD_WIDTH-1:0] out_deriv_weight,
  output logic                         out_last
);
  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NE  = gpej_pkg::EXP_BITS;
  localparam int ACW = gpej_pkg::ACC_W;
  localparam int EW  = gpej_pkg::E_W;
  localparam int D2W = 2 * W - F;       // width of d2, slope term and he*w
  localparam int DH  = D2W / 2;         // upper half of a split operand
  localparam int DL  = D2W - DH;        // lower half of a split operand
  localparam int SW  = D2W + W + 1;     // recombined split product
  localparam int MW  = D2W + 2;         // signed model sum
  localparam int ASH = 2 * F + 1 - 16;  // exponent argument shift

  // clamp a sign and magnitude to the signed output word
  function automatic logic [W-1:0] sat_mag(input logic neg, input logic [SW-1:0] m);
    logic big;
    big = m >= (SW'(1) << (W - 1));
    if (big) return neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return neg ? W'(SW'(0) - m) : W'(m);
  endfunction

  function automatic logic [W-1:0] sat_sum(input logic [MW-1:0] v);
    logic [MW-1:0] m;
    m = v[MW-1] ? MW'(0) - v : v;
    return sat_mag(v[MW-1], SW'(m));
  endfunction

  assign busy = 1'b0;

  // configuration
  logic signed [W-1:0] off_r, slope_r, height_r, centre_r;
  logic [W-1:0] weight_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0; slope_r <= '0; height_r <= '0; centre_r <= '0;
      weight_r <= W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        gpej_pkg::REG_OFFSET: off_r    <= cfg_data;
        gpej_pkg::REG_SLOPE:  slope_r  <= cfg_data;
        gpej_pkg::REG_HEIGHT: height_r <= cfg_data;
        gpej_pkg::REG_CENTRE: centre_r <= cfg_data;
        gpej_pkg::REG_WEIGHT: weight_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: diff as sign and magnitude (magnitude always fits W bits)
  logic v1_r, l1_r, dn1_r;
  logic [W-1:0] md1_r;
  logic signed [W-1:0] x1_r;
  logic signed [W:0] dsum;
  assign dsum = (W+1)'(in_sample_x) - (W+1)'(centre_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
    l1_r  <= in_last;
    x1_r  <= in_sample_x;
    dn1_r <= dsum[W];
    md1_r <= dsum[W] ? W'(-dsum) : W'(dsum);
  end

  // stage 2: d2 and slope term, rounded on magnitude
  logic v2_r, l2_r, dn2_r, sxn2_r;
  logic [W-1:0] md2_r;
  logic [D2W-1:0] d2_2_r, sxm2_r;
  logic [W-1:0] smag, xmag;
  logic [2*W-1:0] sq, sxp;
  assign smag = slope_r[W-1] ? W'(-slope_r) : W'(slope_r);
  assign xmag = x1_r[W-1] ? W'(-x1_r) : W'(x1_r);
  assign sq  = (2*W)'(md1_r) * (2*W)'(md1_r) + ((2*W)'(1) << (F - 1));
  assign sxp = (2*W)'(smag) * (2*W)'(xmag) + ((2*W)'(1) << (F - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    l2_r <= l1_r; dn2_r <= dn1_r; md2_r <= md1_r;
    d2_2_r <= D2W'(sq >> F);
    sxm2_r <= D2W'(sxp >> F);
    sxn2_r <= slope_r[W-1] != x1_r[W-1];
  end

  // stage 3: d2 times weight as two half products
  logic v3_r, l3_r, dn3_r, sxn3_r;
  logic [W-1:0] md3_r;
  logic [D2W-1:0] d2_3_r, sxm3_r;
  logic [DH+W-1:0] ph3_r;
  logic [DL+W-1:0] pl3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    l3_r <= l2_r; dn3_r <= dn2_r; md3_r <= md2_r;
    d2_3_r <= d2_2_r; sxm3_r <= sxm2_r; sxn3_r <= sxn2_r;
    ph3_r <= (DH+W)'(d2_2_r[D2W-1:DL]) * (DH+W)'(weight_r);
    pl3_r <= (DL+W)'(d2_2_r[DL-1:0]) * (DL+W)'(weight_r);
  end

  // stage 4 (chain entry): exponent argument and out-of-range flag
  logic           ev_r  [NE+1];
  logic           el_r  [NE+1];
  logic           ez_r  [NE+1];
  logic           edn_r [NE+1];
  logic           esn_r [NE+1];
  logic [NE-1:0]  ea_r  [NE+1];
  logic [ACW-1:0] acc_r [NE+1];
  logic [W-1:0]   emd_r [NE+1];
  logic [D2W-1:0] ed2_r [NE+1];
  logic [D2W-1:0] esx_r [NE+1];
  logic [SW-1:0] asum;
  assign asum = (SW'(ph3_r) << DL) + SW'(pl3_r) + (SW'(1) << (ASH - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) ev_r[0] <= 1'b0;
    else ev_r[0] <= v3_r;
    el_r[0] <= l3_r; edn_r[0] <= dn3_r; esn_r[0] <= sxn3_r;
    emd_r[0] <= md3_r; ed2_r[0] <= d2_3_r; esx_r[0] <= sxm3_r;
    ea_r[0]  <= asum[ASH +: NE];
    ez_r[0]  <= |asum[SW-1:ASH+NE];
    acc_r[0] <= ACW'(1) << 24;
  end

  // exponential chain: one table factor per stage
  for (genvar k = 0; k < NE; k++) begin : g_exp
    logic [48:0] pr;
    assign pr = 49'(acc_r[k]) * 49'(gpej_pkg::exp_tab(5'(k))) + (49'd1 << 23);
    always_ff @(posedge clk) begin
      if (!rst_n) ev_r[k+1] <= 1'b0;
      else ev_r[k+1] <= ev_r[k];
      el_r[k+1] <= el_r[k]; ez_r[k+1] <= ez_r[k]; ea_r[k+1] <= ea_r[k];
      edn_r[k+1] <= edn_r[k]; esn_r[k+1] <= esn_r[k]; emd_r[k+1] <= emd_r[k];
      ed2_r[k+1] <= ed2_r[k]; esx_r[k+1] <= esx_r[k];
      acc_r[k+1] <= ea_r[k][k] ? ACW'(pr >> 24) : acc_r[k];
    end
  end

  // stage E: e
  logic vE_r, lE_r, dnE_r, sxnE_r;
  logic [EW-1:0] eE_r;
  logic [W-1:0] mdE_r;
  logic [D2W-1:0] d2E_r, sxmE_r;
  logic [ACW:0] er;
  assign er = (ACW+1)'(acc_r[NE]) + (ACW+1)'(128);
  always_ff @(posedge clk) begin
    if (!rst_n) vE_r <= 1'b0;
    else vE_r <= ev_r[NE];
    lE_r <= el_r[NE]; dnE_r <= edn_r[NE]; sxnE_r <= esn_r[NE];
    mdE_r <= emd_r[NE]; d2E_r <= ed2_r[NE]; sxmE_r <= esx_r[NE];
    eE_r <= ez_r[NE] ? '0 : EW'(er >> 8);
  end

  // stage H: he as sign and magnitude
  logic vH_r, lH_r, dnH_r, sxnH_r, henH_r;
  logic [EW-1:0] eH_r;
  logic [W-1:0] mdH_r, hemH_r;
  logic [D2W-1:0] d2H_r, sxmH_r;
  logic [W-1:0] hmag;
  logic [W+EW-1:0] hep;
  assign hmag = height_r[W-1] ? W'(-height_r) : W'(height_r);
  assign hep  = (W+EW)'(hmag) * (W+EW)'(eE_r) + ((W+EW)'(1) << 15);
  always_ff @(posedge clk) begin
    if (!rst_n) vH_r <= 1'b0;
    else vH_r <= vE_r;
    lH_r <= lE_r; eH_r <= eE_r; dnH_r <= dnE_r; sxnH_r <= sxnE_r;
    mdH_r <= mdE_r; d2H_r <= d2E_r; sxmH_r <= sxmE_r;
    hemH_r <= W'(hep >> 16);
    henH_r <= height_r[W-1];
  end

  // stage P: model sum, he*w, d2*he halves
  logic vP_r, lP_r, dnP_r, henP_r;
  logic [EW-1:0] eP_r;
  logic [W-1:0] mdP_r;
  logic [D2W-1:0] hwP_r;
  logic [MW-1:0] mP_r;
  logic [DH+W-1:0] dwhP_r;
  logic [DL+W-1:0] dwlP_r;
  logic [MW-1:0] he_s, off_s, sx_s;
  logic [2*W-1:0] hwp;
  assign he_s  = henH_r ? MW'(0) - MW'(hemH_r) : MW'(hemH_r);
  assign off_s = MW'(off_r);
  assign sx_s  = sxnH_r ? MW'(0) - MW'(sxmH_r) : MW'(sxmH_r);
  assign hwp   = (2*W)'(hemH_r) * (2*W)'(weight_r) + ((2*W)'(1) << (F - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) vP_r <= 1'b0;
    else vP_r <= vH_r;
    lP_r <= lH_r; eP_r <= eH_r; dnP_r <= dnH_r; henP_r <= henH_r; mdP_r <= mdH_r;
    mP_r   <= he_s + off_s + sx_s;
    hwP_r  <= D2W'(hwp >> F);
    dwhP_r <= (DH+W)'(d2H_r[D2W-1:DL]) * (DH+W)'(hemH_r);
    dwlP_r <= (DL+W)'(d2H_r[DL-1:0]) * (DL+W)'(hemH_r);
  end

  // stage Q: weight derivative, he*w*diff halves
  logic vQ_r, lQ_r, dcnQ_r;
  logic [EW-1:0] eQ_r;
  logic [MW-1:0] mQ_r;
  logic [W-1:0] dwQ_r;
  logic [DH+W-1:0] dchQ_r;
  logic [DL+W-1:0] dclQ_r;
  logic [SW-1:0] dwsum;
  assign dwsum = (SW'(dwhP_r) << DL) + SW'(dwlP_r) + (SW'(1) << F);
  always_ff @(posedge clk) begin
    if (!rst_n) vQ_r <= 1'b0;
    else vQ_r <= vP_r;
    lQ_r <= lP_r; eQ_r <= eP_r; mQ_r <= mP_r;
    dwQ_r  <= sat_mag(!henP_r, dwsum >> (F + 1));
    dcnQ_r <= henP_r != dnP_r;
    dchQ_r <= (DH+W)'(hwP_r[D2W-1:DL]) * (DH+W)'(mdP_r);
    dclQ_r <= (DL+W)'(hwP_r[DL-1:0]) * (DL+W)'(mdP_r);
  end

  // output stage: recombine, round and saturate
  logic [SW-1:0] dcsum;
  assign dcsum = (SW'(dchQ_r) << DL) + SW'(dclQ_r) + (SW'(1) << (F - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vQ_r;
    out_last         <= lQ_r;
    out_deriv_height <= eQ_r;
    out_model_value  <= sat_sum(mQ_r);
    out_deriv_centre <= sat_mag(dcnQ_r, dcsum >> F);
    out_deriv_weight <= dwQ_r;
  end
endmodule

>>> hw/rtl/gpej_checker.sv
// Port-level checker for the Gaussian peak evaluator, bound to the top level.
`timescale 1ns / 1ps
module gpej_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [16:0] out_deriv_height
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_eh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_deriv_height <= 17'd65536) else $error("e above one");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("beat after reset");
endmodule

bind gaussian_peak_eval_jacobian_top gpej_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_deriv_height(out_deriv_height)
);
